/* rtl/aes_pkg.sv */
// ---------------------------------------------------------------------------
// aes_pkg
// shared types, tables and round functions for the aes-128 block cipher
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_WORDS  = 44;
    localparam int NUM_ROUNDS = 10;
    localparam int WORD_AW    = 6;
    localparam int RND_W      = 4;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;
    localparam logic [1:0] CFG_IDX_W2   = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_out_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             round;
        logic             ks_start;
        logic             ks_step;
        logic [WORD_AW-1:0] ks_addr;
        logic [WORD_AW-1:0] rd_addr;
        logic [RND_W-1:0] rnd;
        logic             dec;
        logic             last;
    } aes_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

/* rtl/aes_ram.sv */
// ---------------------------------------------------------------------------
// aes_ram
// generic simple dual-port ram (one write port, one read port) with registered read
// ---------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/aes_datapath.sv */
// ---------------------------------------------------------------------------
// aes_datapath
// state register, one round applied per round command, key schedule one word per cycle
// ---------------------------------------------------------------------------
module aes_datapath
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_data,
    input  aes_cmd_t    cmd,
    input  aes_in_t     in_item,
    output aes_out_t    out_item
);
    logic [63:0]  key_high_reg, key_low_reg;
    logic [127:0] win_reg;      // last four schedule words
    logic [127:0] state_reg;
    logic [95:0]  rk0_reg;      // first three round key words from ram reads
    logic [127:0] rk;
    logic [31:0]  rd_word;
    logic [31:0]  new_word;
    logic [31:0]  wr_word;
    logic [127:0] win_next, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx == 2'(REG_KEY_HIGH))
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_we && cfg_idx == 2'(REG_KEY_LOW))
            begin
                key_low_reg <= cfg_data;
            end
        end
    end

    // next schedule word from window
    always_comb
    begin
        logic [31:0] t;
        t = win_reg[31:0];
        if (cmd.ks_addr[1:0] == 2'd0)
        begin
            t = {t[23:0], t[31:24]};
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]}
                ^ {RCON[4'(cmd.ks_addr[WORD_AW-1:2] - 4'd1)], 24'h0};
        end
        new_word = win_reg[127:96] ^ t;
    end

    always_comb
    begin
        win_next = win_reg;
        if (cmd.ks_start)
        begin
            win_next = {key_high_reg, key_low_reg};
        end
        else if (cmd.ks_step && cmd.ks_addr >= 6'd4)
        begin
            win_next = {win_reg[95:0], new_word};
        end
    end

    always_comb
    begin
        case (cmd.ks_addr[1:0])
            2'd0:    wr_word = win_reg[127:96];
            2'd1:    wr_word = win_reg[95:64];
            2'd2:    wr_word = win_reg[63:32];
            default: wr_word = win_reg[31:0];
        endcase
        if (cmd.ks_addr >= 6'd4)
        begin
            wr_word = new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    aes_ram #(.WIDTH(32), .DEPTH(NUM_WORDS)) u_rk_ram (
        .clk   (clk),
        .we    (cmd.ks_step),
        .waddr (cmd.ks_addr),
        .wdata (wr_word),
        .raddr (cmd.rd_addr),
        .rdata (rd_word)
    );

    // round key collects as a shift of words, the last one straight from the ram
    always_ff @(posedge clk)
    begin
        rk0_reg <= {rk0_reg[63:0], rd_word};
    end

    assign rk = {rk0_reg, rd_word};

    // one round
    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_reg[127-8*i -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (cmd.dec)
                begin
                    t[r+4*c] = ISBOX[s[r+4*((c+4-r)%4)]];
                end
                else
                begin
                    t[r+4*c] = SBOX[s[r+4*((c+r)%4)]];
                end
            end
        end
        if (cmd.dec)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t[i] = t[i] ^ rk[127-8*i -: 8];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            if (cmd.dec)
            begin
                // inverse mix by preconditioning: 4x,5x terms then forward mix
                a0 = a0 ^ u; a2 = a2 ^ u; a1 = a1 ^ v; a3 = a3 ^ v;
            end
            x0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            x1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            x2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            x3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            if (!cmd.last)
            begin
                t[4*c] = x0; t[4*c+1] = x1; t[4*c+2] = x2; t[4*c+3] = x3;
            end
            else if (!cmd.dec)
            begin
                t[4*c] = a0; t[4*c+1] = a1; t[4*c+2] = a2; t[4*c+3] = a3;
            end
        end
        if (!cmd.dec)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t[i] = t[i] ^ rk[127-8*i -: 8];
            end
        end
        state_next = state_reg;
        if (cmd.load)
        begin
            state_next = {in_item.block_high, in_item.block_low};
        end
        else if (cmd.round)
        begin
            if (cmd.rnd == 4'd0)
            begin
                state_next = state_reg ^ rk;
            end
            else
            begin
                for (int i = 0; i < 16; i++)
                begin
                    state_next[127-8*i -: 8] = t[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign out_item.result_high = state_reg[127:64];
    assign out_item.result_low  = state_reg[63:0];
endmodule

/* rtl/aes_ctrl.sv */
// ---------------------------------------------------------------------------
// aes_ctrl
// sequencer for key expansion, round key fetch and rounds
// ---------------------------------------------------------------------------
module aes_ctrl
    import aes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic [1:0] cfg_idx,
    input  logic     in_valid,
    input  logic     in_op,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output aes_cmd_t cmd
);
    typedef enum logic [2:0] {S_KSTART, S_KEXP, S_IDLE, S_RUN, S_DONE} state_t;

    state_t           state_reg;
    logic [WORD_AW-1:0] ks_reg;
    logic [RND_W-1:0] rnd_reg;      // rounds applied so far
    logic [2:0]       ph_reg;       // fetch phase within a round, 0..4
    logic             dec_reg;
    logic             rekey_reg;

    logic [RND_W-1:0] krnd;
    logic             accept;
    logic             key_wr;

    assign key_wr    = cfg_we && (cfg_idx < CFG_IDX_W2);
    // a pending or present key write closes the input until the schedule is rebuilt
    assign in_stall  = (state_reg != S_IDLE) || rekey_reg || key_wr;
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_DONE);

    // key round used by the round now being fetched
    assign krnd = dec_reg ? 4'(NUM_ROUNDS - int'(rnd_reg)) : rnd_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.ks_start = (state_reg == S_KSTART);
        cmd.ks_step  = (state_reg == S_KEXP);
        cmd.ks_addr  = ks_reg;
        cmd.rd_addr  = 6'({krnd, 2'b00} + {4'd0, ph_reg[1:0]});
        cmd.load     = accept;
        cmd.round    = (state_reg == S_RUN) && (ph_reg == 3'd4);
        cmd.rnd      = rnd_reg;
        cmd.dec      = dec_reg;
        cmd.last     = (rnd_reg == 4'(NUM_ROUNDS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_KSTART;
            ks_reg    <= '0;
            rnd_reg   <= '0;
            ph_reg    <= '0;
            dec_reg   <= 1'b0;
            rekey_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_KSTART)
            begin
                rekey_reg <= key_wr;
            end
            else if (key_wr)
            begin
                rekey_reg <= 1'b1;
            end
            case (state_reg)
                S_KSTART:
                begin
                    ks_reg    <= '0;
                    state_reg <= S_KEXP;
                end
                S_KEXP:
                begin
                    ks_reg <= ks_reg + 6'd1;
                    if (ks_reg == 6'(NUM_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (rekey_reg || key_wr)
                    begin
                        state_reg <= S_KSTART;
                    end
                    else if (in_valid)
                    begin
                        dec_reg   <= in_op;
                        rnd_reg   <= '0;
                        ph_reg    <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (ph_reg == 3'd4)
                    begin
                        ph_reg <= '0;
                        rnd_reg <= rnd_reg + 4'd1;
                        if (rnd_reg == 4'(NUM_ROUNDS))
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_DONE:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_KSTART;
                end
            endcase
        end
    end
endmodule

/* rtl/aes128_block_cipher.sv */
// ---------------------------------------------------------------------------
// aes128_block_cipher
// aes-128 ecb encrypt and decrypt with on-chip key schedule
// ---------------------------------------------------------------------------
// channel   signals                     direction
// in        in_valid in_stall in_data    block and op in
// out       out_valid out_stall out_data result out
// cfg       cfg_we cfg_idx cfg_data      key halves
//
// an item goes through eleven round steps; each one reads the four round key
// words from the key ram and then applies the round.
// the result shows on the next cycle; a new item is taken only once the last
// result has left through the done state and the block is idle again.
// after reset and after each key write the schedule is rebuilt, one word per
// cycle into the ram, while in_stall is high.
// out_stall holds the result; no new item is taken until it is taken.
// ---------------------------------------------------------------------------
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  aes_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output aes_out_t    out_data
);
    aes_cmd_t cmd;

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .in_valid  (in_valid),
        .in_op     (in_data.op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    aes_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .in_item  (in_data),
        .out_item (out_data)
    );
endmodule

/* rtl/aes_checker.sv */
// ---------------------------------------------------------------------------
// aes_checker
// port-level checks for the aes-128 block cipher
// ---------------------------------------------------------------------------
module aes_checker
    import aes_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input aes_out_t out_data
);
    // item accepted means no result can appear next cycle
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result too early");

    // never ready while a result waits
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
